>>> src/mrw_pkg.sv
package mrw_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_SPLIT,
        ST_POW_SQ,
        ST_POW_SQ_WAIT,
        ST_POW_MUL,
        ST_POW_MUL_WAIT,
        ST_POW_NEXT,
        ST_LOOP,
        ST_LOOP_WAIT,
        ST_FIN_INVALID,
        ST_FIN_WITNESS,
        ST_FIN_FINAL
    } state_t;

    typedef enum logic [1:0] {
        RES_INVALID,
        RES_WITNESS,
        RES_FINAL
    } res_kind_t;

    typedef struct packed {
        logic      load;
        logic      reduce_step;
        logic      split_step;
        logic      pow_init;
        logic      mul_start;
        logic      mul_by_base;
        logic      save_prev;
        logic      idx_dec;
        logic      t_dec;
        logic      publish;
        res_kind_t pub_kind;
    } cmd_t;

    typedef struct packed {
        logic n_small;
        logic idx_zero;
        logic u_odd;
        logic u_bit;
        logic mul_busy;
        logic t_zero;
        logic root_found;
        logic out_free;
    } status_t;

endpackage

>>> src/mrw_ctrl.sv
module mrw_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             idle,
    input  mrw_pkg::status_t st,
    output mrw_pkg::cmd_t    cmd
);

    mrw_pkg::state_t state_reg;
    mrw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.pub_kind = mrw_pkg::RES_FINAL;
        idle       = (state_reg == mrw_pkg::ST_IDLE);
        case (state_reg)
            mrw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = mrw_pkg::ST_CHECK;
                end
            end
            mrw_pkg::ST_CHECK:
            begin
                state_next = st.n_small ? mrw_pkg::ST_FIN_INVALID : mrw_pkg::ST_REDUCE;
            end
            mrw_pkg::ST_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
                if (st.idx_zero)
                begin
                    state_next = mrw_pkg::ST_SPLIT;
                end
            end
            mrw_pkg::ST_SPLIT:
            begin
                if (st.u_odd)
                begin
                    cmd.pow_init = 1'b1;
                    state_next   = mrw_pkg::ST_POW_SQ;
                end
                else
                begin
                    cmd.split_step = 1'b1;
                end
            end
            mrw_pkg::ST_POW_SQ:
            begin
                cmd.mul_start = 1'b1;
                state_next    = mrw_pkg::ST_POW_SQ_WAIT;
            end
            mrw_pkg::ST_POW_SQ_WAIT:
            begin
                if (!st.mul_busy)
                begin
                    state_next = st.u_bit ? mrw_pkg::ST_POW_MUL : mrw_pkg::ST_POW_NEXT;
                end
            end
            mrw_pkg::ST_POW_MUL:
            begin
                cmd.mul_start   = 1'b1;
                cmd.mul_by_base = 1'b1;
                state_next      = mrw_pkg::ST_POW_MUL_WAIT;
            end
            mrw_pkg::ST_POW_MUL_WAIT:
            begin
                if (!st.mul_busy)
                begin
                    state_next = mrw_pkg::ST_POW_NEXT;
                end
            end
            mrw_pkg::ST_POW_NEXT:
            begin
                if (st.idx_zero)
                begin
                    state_next = mrw_pkg::ST_LOOP;
                end
                else
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = mrw_pkg::ST_POW_SQ;
                end
            end
            mrw_pkg::ST_LOOP:
            begin
                if (st.t_zero)
                begin
                    state_next = mrw_pkg::ST_FIN_FINAL;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.save_prev = 1'b1;
                    state_next    = mrw_pkg::ST_LOOP_WAIT;
                end
            end
            mrw_pkg::ST_LOOP_WAIT:
            begin
                if (!st.mul_busy)
                begin
                    if (st.root_found)
                    begin
                        state_next = mrw_pkg::ST_FIN_WITNESS;
                    end
                    else
                    begin
                        cmd.t_dec  = 1'b1;
                        state_next = mrw_pkg::ST_LOOP;
                    end
                end
            end
            mrw_pkg::ST_FIN_INVALID,
            mrw_pkg::ST_FIN_WITNESS,
            mrw_pkg::ST_FIN_FINAL:
            begin
                if (state_reg == mrw_pkg::ST_FIN_INVALID)
                begin
                    cmd.pub_kind = mrw_pkg::RES_INVALID;
                end
                else if (state_reg == mrw_pkg::ST_FIN_WITNESS)
                begin
                    cmd.pub_kind = mrw_pkg::RES_WITNESS;
                end
                if (st.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = mrw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/mrw_dp.sv
module mrw_dp
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      candidate,
    input  logic [31:0]      base,
    input  mrw_pkg::cmd_t    cmd,
    output mrw_pkg::status_t st,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             proven_composite,
    output logic             invalid_candidate
);

    localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [IW-1:0] IDX_TOP = IW'(WIDTH - 1);

    logic [WIDTH-1:0] n_reg;
    logic [WIDTH-1:0] base_raw_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] u_reg;
    logic [IW-1:0]    t_reg;
    logic [IW-1:0]    idx_reg;
    logic [WIDTH-1:0] x_reg;
    logic [WIDTH-1:0] prev_reg;
    logic [WIDTH-1:0] mx_reg;
    logic [WIDTH-1:0] my_reg;
    logic [WIDTH-1:0] mr_reg;
    logic [IW-1:0]    mi_reg;
    logic             busy_reg;
    logic             out_valid_reg;
    logic             composite_reg;
    logic             invalid_reg;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH:0]   dbl;
    logic [WIDTH-1:0] dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] mr_next;
    logic [WIDTH-1:0] n_m1;

    assign n_m1 = n_reg - WIDTH'(1);

    // reduce the base one bit per step: shift in, subtract if not below n
    always_comb
    begin
        rem_sh   = {a_reg, base_raw_reg[idx_reg]};
        rem_next = (rem_sh >= {1'b0, n_reg}) ? WIDTH'(rem_sh - {1'b0, n_reg})
                                            : rem_sh[WIDTH-1:0];
    end

    // interleaved modular multiply: double, then add the multiplicand on a set bit
    always_comb
    begin
        dbl     = {mr_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, n_reg}) ? WIDTH'(dbl - {1'b0, n_reg}) : dbl[WIDTH-1:0];
        sum     = {1'b0, dbl_red} + {1'b0, mx_reg};
        if (my_reg[mi_reg])
        begin
            mr_next = (sum >= {1'b0, n_reg}) ? WIDTH'(sum - {1'b0, n_reg})
                                            : sum[WIDTH-1:0];
        end
        else
        begin
            mr_next = dbl_red;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg        <= WIDTH'(candidate);
            base_raw_reg <= WIDTH'(base);
            u_reg        <= WIDTH'(candidate) - WIDTH'(1);
        end
        if (cmd.split_step)
        begin
            u_reg <= u_reg >> 1;
        end
        if (cmd.reduce_step)
        begin
            a_reg <= rem_next;
        end
        else if (cmd.load)
        begin
            a_reg <= '0;
        end
        if (cmd.pow_init)
        begin
            x_reg <= WIDTH'(1);
        end
        else if (busy_reg && mi_reg == '0)
        begin
            x_reg <= mr_next;
        end
        if (cmd.save_prev)
        begin
            prev_reg <= x_reg;
        end
        if (cmd.mul_start)
        begin
            mx_reg <= cmd.mul_by_base ? a_reg : x_reg;
            my_reg <= x_reg;
            mr_reg <= '0;
        end
        else if (busy_reg)
        begin
            mr_reg <= mr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            t_reg         <= '0;
            mi_reg        <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            composite_reg <= 1'b0;
            invalid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.pow_init)
            begin
                idx_reg <= IDX_TOP;
            end
            else if (cmd.idx_dec || (cmd.reduce_step && idx_reg != '0))
            begin
                idx_reg <= idx_reg - IW'(1);
            end
            if (cmd.load)
            begin
                t_reg <= '0;
            end
            else if (cmd.split_step)
            begin
                t_reg <= t_reg + IW'(1);
            end
            else if (cmd.t_dec)
            begin
                t_reg <= t_reg - IW'(1);
            end
            if (cmd.mul_start)
            begin
                busy_reg <= 1'b1;
                mi_reg   <= IDX_TOP;
            end
            else if (busy_reg)
            begin
                if (mi_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    mi_reg <= mi_reg - IW'(1);
                end
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
                case (cmd.pub_kind)
                    mrw_pkg::RES_INVALID:
                    begin
                        composite_reg <= 1'b0;
                        invalid_reg   <= 1'b1;
                    end
                    mrw_pkg::RES_WITNESS:
                    begin
                        composite_reg <= 1'b1;
                        invalid_reg   <= 1'b0;
                    end
                    default:
                    begin
                        composite_reg <= (x_reg != WIDTH'(1));
                        invalid_reg   <= 1'b0;
                    end
                endcase
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        st.n_small    = (n_reg < WIDTH'(2));
        st.idx_zero   = (idx_reg == '0);
        st.u_odd      = u_reg[0];
        st.u_bit      = u_reg[idx_reg];
        st.mul_busy   = busy_reg;
        st.t_zero     = (t_reg == '0);
        st.root_found = (x_reg == WIDTH'(1)) && (prev_reg != WIDTH'(1)) && (prev_reg != n_m1);
        st.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid         = out_valid_reg;
    assign proven_composite  = composite_reg;
    assign invalid_candidate = invalid_reg;

endmodule

>>> src/miller_rabin_witness_test.sv
// Miller-Rabin witness test, one round with a caller-supplied base. Each transfer on
// the slave side carries a candidate n and a base a; one transfer on the master side
// answers whether a proves n composite, or flags n as invalid when it is 0 or 1. Both
// fields are taken modulo 2^WIDTH before use. The block works on one candidate at a
// time: the base is reduced modulo n bit by bit, n-1 is split into 2^t * u at one
// bit per cycle, a^u mod n runs left to right over all WIDTH bits of u, and up to t
// squarings follow, ending early when a nontrivial root of 1 is found. Every modular
// product goes through a single shared interleaved shift-add multiplier. A new item is
// taken whenever the block is idle, even while the last answer still waits in the
// output register.
module miller_rabin_witness_test
#(
    parameter int WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] candidate, [63:32] base
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] proven_composite, [1] invalid_candidate, [7:2] zero
);

    mrw_pkg::cmd_t    cmd;
    mrw_pkg::status_t st;
    logic             idle;
    logic             proven_composite;
    logic             invalid_candidate;

    // hand the item to the datapath on the transfer; the controller leaves idle at once
    assign s_tready = idle;

    mrw_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (s_tvalid),
        .idle  (idle),
        .st    (st),
        .cmd   (cmd)
    );

    mrw_dp #(.WIDTH(WIDTH)) u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .candidate         (s_tdata[31:0]),
        .base              (s_tdata[63:32]),
        .cmd               (cmd),
        .st                (st),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .proven_composite  (proven_composite),
        .invalid_candidate (invalid_candidate)
    );

    assign m_tdata = {6'b0, invalid_candidate, proven_composite};

endmodule

>>> src/mrw_checker.sv
module mrw_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_invalid_not_composite: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("invalid candidate reported composite");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:2] == 6'b0)
        else $error("padding bits set");

endmodule

bind miller_rabin_witness_test mrw_checker u_mrw_checker (.*);

>>> tb/sv/miller_rabin_witness_test_tb.sv
module miller_rabin_witness_test_tb;

    localparam int WIDTH     = 32;
    localparam int LATENCY   = 2400;
    localparam int WDOG_MAX  = 40000;
    localparam int N_RANDOM  = 250;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] candidate;
    } test_item_t;

    typedef struct packed {
        logic invalid_candidate;
        logic proven_composite;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    test_item_t pending_q[$];
    verdict_t   verdict_q[$];

    int  mismatches;
    int  wdog;
    bit  quiet;          // no idling in the last part of the run
    bit  hold_sink;      // receiver holds off for a long stretch
    bit  pause_source;   // sender waits until the block drains
    int  src_gap;
    int  sink_gap;
    int  sink_hold_cnt;

    miller_rabin_witness_test #(.WIDTH(WIDTH)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Exact modular product by doubling and adding, one bit of y at a time.
    function automatic logic [63:0] mod_product(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] n);
        logic [64:0] acc;
        acc = 0;
        for (int i = 63; i >= 0; i--)
        begin
            acc = (acc << 1) % n;
            if (y[i])
                acc = (acc + x) % n;
        end
        return acc[63:0];
    endfunction

    function automatic logic [63:0] mod_power(logic [63:0] a, logic [63:0] e,
                                              logic [63:0] n);
        logic [63:0] r;
        r = 1;
        for (int i = 63; i >= 0; i--)
        begin
            r = mod_product(r, r, n);
            if (e[i])
                r = mod_product(r, a, n);
        end
        return r;
    endfunction

    function automatic verdict_t witness_verdict(test_item_t it);
        logic [63:0] n, a, u, x, y;
        int          t;
        verdict_t    v;
        n = 64'(it.candidate);
        a = 64'(it.base);
        v = '0;
        if (n < 2)
        begin
            v.invalid_candidate = 1'b1;
            return v;
        end
        u = n - 1;
        t = 0;
        while (u != 0 && !u[0])
        begin
            u = u >> 1;
            t++;
        end
        x = mod_power(a % n, u, n);
        for (int i = 0; i < t; i++)
        begin
            y = mod_product(x, x, n);
            if (y == 1 && x != 1 && x != n - 1)
            begin
                v.proven_composite = 1'b1;
                return v;
            end
            x = y;
        end
        v.proven_composite = (x != 1);
        return v;
    endfunction

    // Driver: offer the head of the pending queue, advance on each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  <= 0;
        end
        else
        begin
            logic busy;
            logic fire;
            busy = s_tvalid && !s_tready;
            fire = s_tvalid && s_tready;
            if (fire)
                void'(pending_q.pop_front());
            if (busy)
            begin
                // hold the current item until it is taken
            end
            else if (src_gap > 0)
            begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pause_source || pending_q.size() == 0)
                s_tvalid <= 1'b0;
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_q[0];
                if (!quiet && $urandom_range(0, 5) == 0)
                    src_gap <= $urandom_range(1, 7);
            end
        end
    end

    // Monitor: check every result transfer against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready      <= 1'b0;
            sink_gap      <= 0;
            sink_hold_cnt <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", m_tdata);
                end
                else
                begin
                    verdict_t want;
                    want = verdict_q.pop_front();
                    if (m_tdata !== {6'b0, want})
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %h actual %h",
                                     {6'b0, want}, m_tdata);
                    end
                end
            end
            if (hold_sink)
            begin
                // long hold-off, counted here while the sender keeps offering
                m_tready <= 1'b0;
                if (sink_hold_cnt < 12000)
                    sink_hold_cnt <= sink_hold_cnt + 1;
                else
                    hold_sink <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0)
                    sink_gap <= $urandom_range(1, 7);
            end
        end
    end

    // Predict on each accepted input; count idle cycles for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            verdict_q.insert(verdict_q.size(), witness_verdict(test_item_t'(s_tdata)));
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
    end

    always @(posedge clk)
    begin
        if (wdog >= WDOG_MAX)
        begin
            $display("miller_rabin_witness_test_tb failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_prime_like();
        logic [31:0] p[8] = '{32'd2, 32'd3, 32'd7, 32'd97, 32'd65537,
                              32'd2147483647, 32'd4294967291, 32'd1000003};
        return p[$urandom_range(0, 7)];
    endfunction

    task automatic add_item(logic [31:0] n, logic [31:0] a);
        test_item_t it;
        it.candidate = n;
        it.base      = a;
        pending_q.insert(pending_q.size(), it);
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] n;
        logic [31:0] a;
        int          sel;
        mismatches   = 0;
        wdog         = 0;
        quiet        = 0;
        hold_sink    = 0;
        pause_source = 0;
        rst_n        = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: invalid candidates, field extremes, even n, base multiple of n
        add_item(32'd0, 32'd5);
        add_item(32'd1, 32'hFFFF_FFFF);
        add_item(32'd2, 32'd1);
        add_item(32'd2, 32'd2);
        add_item(32'd2, 32'd0);
        add_item(32'd3, 32'd2);
        add_item(32'd4, 32'd3);
        add_item(32'd9, 32'd8);
        add_item(32'd561, 32'd2);
        add_item(32'd561, 32'd50);
        add_item(32'd221, 32'd174);
        add_item(32'd221, 32'd137);
        add_item(32'd100, 32'd7);
        add_item(32'd15, 32'd45);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(32'hFFFF_FFFB, 32'h0000_0002);
        add_item(32'hFFFF_FFFB, 32'hFFFF_FFFF);
        add_item(32'h8000_0000, 32'h1234_5678);
        add_item(32'h7FFF_FFFF, 32'd3);
        add_item(32'hAAAA_AAAB, 32'h5555_5555);

        // long receiver stall while the sender keeps offering
        hold_sink = 1;
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       n = $urandom_range(0, 1);
                1:       n = $urandom_range(2, 64);
                2, 3:    n = rand_prime_like();
                4:       n = rand_prime_like() * rand_prime_like() | 32'd1;
                default: n = $urandom;
            endcase
            if ($urandom_range(0, 7) == 0)
                a = n * $urandom_range(0, 3);
            else if ($urandom_range(0, 3) == 0)
                a = $urandom;
            else
                a = (n > 2) ? $urandom_range(1, n - 1) : $urandom;
            add_item(n, a);
        end

        // sender pause midway until every result is back
        while (pending_q.size() > N_RANDOM / 2)
            @(posedge clk);
        pause_source = 1;
        while (s_tvalid || verdict_q.size() != 0)
            @(posedge clk);
        pause_source = 0;

        // no idling in the last part of the run
        while (pending_q.size() > 30)
            @(posedge clk);
        quiet = 1;
        wait_drained();
        repeat (LATENCY) @(posedge clk);

        if (mismatches == 0 && verdict_q.size() == 0)
            $display("miller_rabin_witness_test_tb passed");
        else
            $display("miller_rabin_witness_test_tb failed");
        $finish;
    end

endmodule
